FILE: design/cwmc_pkg.sv
`default_nettype none

package cwmc_pkg;

	// Widths of the sample path.
	localparam int unsigned SAMPLE_W = 8;
	localparam int unsigned FRAC_W   = 6;
	localparam int unsigned TAP_W    = 7;
	localparam int unsigned WEIGHT_W = 9;
	localparam int unsigned OFFSET_W = 8;

	// Configuration port.
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 9;

	localparam logic [CFG_INDEX_W-1:0] REG_WEIGHTED_ENABLE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LOG_WD          = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_L0       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_L1       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_L0       = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_L1       = 3'd5;

	// Bilinear rounding constant and the eighth-pel span.
	localparam logic [13:0] BILIN_ROUND = 14'd32;
	localparam logic [3:0]  PEL_SPAN    = 4'd8;

	// The four bilinear taps of one reference.
	typedef struct packed {
		logic [TAP_W-1:0] tl;
		logic [TAP_W-1:0] tr;
		logic [TAP_W-1:0] bl;
		logic [TAP_W-1:0] br;
	} taps_t;

	// Tap weights from the fraction: bits 5..3 are yfrac, bits 2..0 are xfrac.
	// The factors are held at the tap width so that 8 times 8 does not wrap.
	function automatic taps_t bilin_taps(input logic [FRAC_W-1:0] frac);
		logic [TAP_W-1:0] fx;
		logic [TAP_W-1:0] fy;
		logic [TAP_W-1:0] gx;
		logic [TAP_W-1:0] gy;
		taps_t            t;
		fx   = TAP_W'(frac[2:0]);
		fy   = TAP_W'(frac[5:3]);
		gx   = TAP_W'(PEL_SPAN) - fx;
		gy   = TAP_W'(PEL_SPAN) - fy;
		t.tl = gx * gy;
		t.tr = fx * gy;
		t.bl = gx * fy;
		t.br = fx * fy;
		return t;
	endfunction

endpackage

`default_nettype wire

FILE: design/chroma_weighted_motion_comp_sample_core.sv
`default_nettype none

// An accepted input transaction passes through each registered stage in turn to the output.
// Throughput: one transaction per clock unless the output stalls; every stage holds its
// own valid bit, so a stall at the output only backs up as far as the first empty stage.
// Reset: arst_n clears all valid bits and loads the weighting registers with
// weighted_enable 0, log_wd 0, weights 1 and offsets 0.
module chroma_weighted_motion_comp_sample_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,

	input  wire logic                                cfg_we,
	input  wire logic [cwmc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [cwmc_pkg::CFG_DATA_W-1:0]     cfg_data,

	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [cwmc_pkg::SAMPLE_W-1:0]       ref0_tl,
	input  wire logic [cwmc_pkg::SAMPLE_W-1:0]       ref0_tr,
	input  wire logic [cwmc_pkg::SAMPLE_W-1:0]       ref0_bl,
	input  wire logic [cwmc_pkg::SAMPLE_W-1:0]       ref0_br,
	input  wire logic [cwmc_pkg::FRAC_W-1:0]         frac0,
	input  wire logic [cwmc_pkg::SAMPLE_W-1:0]       ref1_tl,
	input  wire logic [cwmc_pkg::SAMPLE_W-1:0]       ref1_tr,
	input  wire logic [cwmc_pkg::SAMPLE_W-1:0]       ref1_bl,
	input  wire logic [cwmc_pkg::SAMPLE_W-1:0]       ref1_br,
	input  wire logic [cwmc_pkg::FRAC_W-1:0]         frac1,
	input  wire logic                                bi_mode,
	input  wire logic                                list_sel,

	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [cwmc_pkg::SAMPLE_W-1:0]            pred_sample
);

	// Weighting registers.
	logic                                   weighted_enable_q;
	logic [2:0]                             log_wd_q;
	logic signed [cwmc_pkg::WEIGHT_W-1:0]   weight_l0_q;
	logic signed [cwmc_pkg::WEIGHT_W-1:0]   weight_l1_q;
	logic signed [cwmc_pkg::OFFSET_W-1:0]   offset_l0_q;
	logic signed [cwmc_pkg::OFFSET_W-1:0]   offset_l1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weighted_enable_q <= 1'b0;
			log_wd_q          <= 3'd0;
			weight_l0_q       <= 9'sd1;
			weight_l1_q       <= 9'sd1;
			offset_l0_q       <= 8'sd0;
			offset_l1_q       <= 8'sd0;
		end else if (cfg_we) begin
			case (cfg_index)
				cwmc_pkg::REG_WEIGHTED_ENABLE: weighted_enable_q <= cfg_data[0];
				cwmc_pkg::REG_LOG_WD:          log_wd_q          <= cfg_data[2:0];
				cwmc_pkg::REG_WEIGHT_L0:       weight_l0_q       <= $signed(cfg_data);
				cwmc_pkg::REG_WEIGHT_L1:       weight_l1_q       <= $signed(cfg_data);
				cwmc_pkg::REG_OFFSET_L0:       offset_l0_q       <= $signed(cfg_data[7:0]);
				cwmc_pkg::REG_OFFSET_L1:       offset_l1_q       <= $signed(cfg_data[7:0]);
				default: begin
				end
			endcase
		end
	end

	// Stage valid bits and the ready chain; a stage takes new data when it is
	// empty or when the stage after it moves on.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5     = !v_s5 || !out_stall;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// Stage 1: capture the samples and form the bilinear tap weights.
	logic [cwmc_pkg::SAMPLE_W-1:0] r0_tl_s1, r0_tr_s1, r0_bl_s1, r0_br_s1;
	logic [cwmc_pkg::SAMPLE_W-1:0] r1_tl_s1, r1_tr_s1, r1_bl_s1, r1_br_s1;
	cwmc_pkg::taps_t               taps0_s1, taps1_s1;
	logic                          bi_s1, lsel_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			r0_tl_s1 <= ref0_tl;
			r0_tr_s1 <= ref0_tr;
			r0_bl_s1 <= ref0_bl;
			r0_br_s1 <= ref0_br;
			r1_tl_s1 <= ref1_tl;
			r1_tr_s1 <= ref1_tr;
			r1_bl_s1 <= ref1_bl;
			r1_br_s1 <= ref1_br;
			taps0_s1 <= cwmc_pkg::bilin_taps(frac0);
			taps1_s1 <= cwmc_pkg::bilin_taps(frac1);
			bi_s1    <= bi_mode;
			lsel_s1  <= list_sel;
		end
	end

	// Stage 2: bilinear interpolation of both references.
	logic [13:0]                   acc0, acc1;
	logic [cwmc_pkg::SAMPLE_W-1:0] p0_s2, p1_s2;
	logic                          bi_s2, lsel_s2;

	always_comb begin
		acc0 = 14'(taps0_s1.tl) * 14'(r0_tl_s1) + 14'(taps0_s1.tr) * 14'(r0_tr_s1)
		     + 14'(taps0_s1.bl) * 14'(r0_bl_s1) + 14'(taps0_s1.br) * 14'(r0_br_s1)
		     + cwmc_pkg::BILIN_ROUND;
		acc1 = 14'(taps1_s1.tl) * 14'(r1_tl_s1) + 14'(taps1_s1.tr) * 14'(r1_tr_s1)
		     + 14'(taps1_s1.bl) * 14'(r1_bl_s1) + 14'(taps1_s1.br) * 14'(r1_br_s1)
		     + cwmc_pkg::BILIN_ROUND;
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			p0_s2   <= acc0[13:6];
			p1_s2   <= acc1[13:6];
			bi_s2   <= bi_s1;
			lsel_s2 <= lsel_s1;
		end
	end

	// Stage 3: weight multiplies. Plain prediction uses unit weights, and the
	// rounding term, shift and offset are chosen here for stage 4 and 5.
	logic signed [cwmc_pkg::WEIGHT_W-1:0] w0_eff, w1_eff;
	logic [7:0]                           rnd_nxt;
	logic [3:0]                           sh_nxt;
	logic signed [8:0]                    off_sum;
	logic signed [cwmc_pkg::OFFSET_W-1:0] off_nxt;
	logic signed [17:0]                   prod0_s3, prod1_s3;
	logic [7:0]                           rnd_s3;
	logic [3:0]                           sh_s3;
	logic signed [cwmc_pkg::OFFSET_W-1:0] off_s3;

	always_comb begin
		off_sum = (9'(offset_l0_q) + 9'(offset_l1_q) + 9'sd1) >>> 1;
		w0_eff  = 9'sd1;
		w1_eff  = 9'sd0;
		rnd_nxt = 8'd0;
		sh_nxt  = 4'd0;
		off_nxt = 8'sd0;
		if (!bi_s2) begin
			if (weighted_enable_q) begin
				w0_eff  = lsel_s2 ? weight_l1_q : weight_l0_q;
				sh_nxt  = {1'b0, log_wd_q};
				off_nxt = lsel_s2 ? offset_l1_q : offset_l0_q;
				if (log_wd_q != 3'd0) begin
					rnd_nxt = 8'd1 << (log_wd_q - 3'd1);
				end
			end
		end else begin
			if (weighted_enable_q) begin
				w0_eff  = weight_l0_q;
				w1_eff  = weight_l1_q;
				rnd_nxt = 8'd1 << log_wd_q;
				sh_nxt  = {1'b0, log_wd_q} + 4'd1;
				off_nxt = off_sum[7:0];
			end else begin
				w1_eff  = 9'sd1;
				rnd_nxt = 8'd1;
				sh_nxt  = 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			prod0_s3 <= $signed({1'b0, p0_s2}) * w0_eff;
			prod1_s3 <= $signed({1'b0, p1_s2}) * w1_eff;
			rnd_s3   <= rnd_nxt;
			sh_s3    <= sh_nxt;
			off_s3   <= off_nxt;
		end
	end

	// Stage 4: sum, round and arithmetic shift by the denominator.
	logic signed [19:0]                   wsum;
	logic signed [19:0]                   val_s4;
	logic signed [cwmc_pkg::OFFSET_W-1:0] off_s4;

	assign wsum = 20'(prod0_s3) + 20'(prod1_s3) + $signed({12'd0, rnd_s3});

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			val_s4 <= wsum >>> sh_s3;
			off_s4 <= off_s3;
		end
	end

	// Stage 5: add the offset and clip into the sample range.
	logic signed [20:0]            fin;
	logic [cwmc_pkg::SAMPLE_W-1:0] clip_val;

	always_comb begin
		fin = 21'(val_s4) + 21'(off_s4);
		if (fin[20]) begin
			clip_val = 8'd0;
		end else if (fin[19:8] != 12'd0) begin
			clip_val = 8'd255;
		end else begin
			clip_val = fin[7:0];
		end
	end

	logic [cwmc_pkg::SAMPLE_W-1:0] pred_s5;

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			pred_s5 <= clip_val;
		end
	end

	assign out_valid   = v_s5;
	assign pred_sample = pred_s5;

endmodule

`default_nettype wire
